// File: hw/rtl/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// Shared types, constants and the CORDIC arctangent table for the planar
// odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

    localparam int CORDIC_STEPS = 16;          // 8 .. 24
    localparam int ITER_W       = 5;           // indexes up to 24 table entries
    localparam int XY_W         = 40;          // CORDIC x/y datapath width
    localparam int ACC_W        = 34;          // product accumulator width

    localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(652032875);
    localparam logic signed [31:0]     ANG_90   = 32'sd1073741824;

    localparam logic OP_HEADING  = 1'b0;
    localparam logic OP_VELOCITY = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic        [31:0] stamp;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] orient_z;
        logic signed [15:0] orient_w;
        logic signed [15:0] echo_vel_x;
        logic signed [15:0] echo_vel_y;
        logic        [31:0] out_stamp;
    } t_out_item;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933405;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335086;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;
            5'd15: v = 32'd20860;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2607;
            5'd19: v = 32'd1303;
            5'd20: v = 32'd651;
            5'd21: v = 32'd325;
            5'd22: v = 32'd162;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/planar_odometry_integrator_top.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator_top
// Heading items run the multiply, setup and CORDIC vectoring states.
// Velocity items run rotation, cos/sin, multiply and second rotation; one shared
// CORDIC stage and one shared 34x32 multiplier, one item in flight at a time.
// Velocity items with non-positive dt only store their stamp. A finished result
// sits in the output register while the next item is taken.
// Synchronous active-low reset clears heading, position and last stamp.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_top
    import poi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_HMUL  = 8'b0000_0010,
        ST_HINIT = 8'b0000_0100,
        ST_HCORD = 8'b0000_1000,
        ST_VROT1 = 8'b0001_0000,
        ST_VCS   = 8'b0010_0000,
        ST_VMUL  = 8'b0100_0000,
        ST_VROT2 = 8'b1000_0000
    } t_state;

    t_state                   r_state;
    logic                     r_vout;      // waiting to hand out the result
    logic      [ITER_W-1:0]   r_cnt;
    t_in_item                 r_item;
    logic      [15:0]         r_heading;
    logic signed [31:0]       r_pos_x, r_pos_y;
    logic      [31:0]         r_last_stamp;
    logic signed [31:0]       r_dt;
    logic signed [XY_W-1:0]   r_x, r_y;
    logic      [31:0]         r_z;
    logic                     r_flip;
    logic signed [15:0]       r_c, r_s;
    logic signed [ACC_W-1:0]  r_acc_a, r_acc_b;
    logic signed [63:0]       r_prod;
    logic                     r_out_valid;
    t_out_item                r_out;

    function automatic logic signed [15:0] round_q14(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        r = (v + XY_W'(32768)) >>> 16;
        if (r > XY_W'(16384))
            r = XY_W'(16384);
        else if (r < -XY_W'(16384))
            r = -XY_W'(16384);
        return r[15:0];
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] pos,
                                                   input logic signed [63:0] prod);
        logic signed [63:0] rnd;
        logic signed [39:0] sum;
        rnd = (prod + 64'sd33554432) >>> 26;
        sum = 40'(pos) + rnd[39:0];
        if (sum > 40'sd2147483647)
            sum = 40'sd2147483647;
        else if (sum < -40'sd2147483648)
            sum = -40'sd2147483648;
        return sum[31:0];
    endfunction

    // accept and dt check
    logic              in_xfer;
    logic signed [31:0] dt_new;
    assign o_in_ready = (r_state == ST_IDLE) && !r_vout;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign dt_new     = signed'(i_in_data.stamp - r_last_stamp);

    // first rotation angle: heading folded into +-90 deg
    logic signed [32:0] ang_raw;
    logic signed [32:0] ang_fold;
    logic               ang_flip;
    always_comb begin
        ang_raw  = 33'(signed'({r_heading, 16'b0}));
        ang_fold = ang_raw;
        ang_flip = 1'b0;
        if (ang_raw > 33'(ANG_90)) begin
            ang_fold = ang_raw - 33'sd2147483648;
            ang_flip = 1'b1;
        end else if (ang_raw < -33'(ANG_90)) begin
            ang_fold = ang_raw + 33'sd2147483648;
            ang_flip = 1'b1;
        end
    end

    // shared CORDIC micro-rotation
    logic                   vec_mode, dir_pos, last_iter;
    logic signed [XY_W-1:0] sh_x, sh_y, n_x, n_y;
    logic      [31:0]       atan_v, n_z;
    assign vec_mode  = (r_state == ST_HCORD);
    assign dir_pos   = vec_mode ? r_y[XY_W-1] : !r_z[31];
    assign sh_x      = r_x >>> r_cnt;
    assign sh_y      = r_y >>> r_cnt;
    assign atan_v    = atan_lut(r_cnt);
    assign last_iter = (r_cnt == ITER_W'(CORDIC_STEPS - 1));
    assign n_x       = dir_pos ? r_x - sh_y : r_x + sh_y;
    assign n_y       = dir_pos ? r_y + sh_x : r_y - sh_x;
    assign n_z       = dir_pos ? r_z - atan_v : r_z + atan_v;

    // shared multiplier operand select
    logic signed [ACC_W-1:0] mul_a;
    logic signed [31:0]      mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_HMUL) begin
            case (r_cnt)
                5'd0:    begin mul_a = ACC_W'(r_item.quat_w); mul_b = 32'(r_item.quat_z); end
                5'd1:    begin mul_a = ACC_W'(r_item.quat_x); mul_b = 32'(r_item.quat_y); end
                5'd2:    begin mul_a = ACC_W'(r_item.quat_y); mul_b = 32'(r_item.quat_y); end
                default: begin mul_a = ACC_W'(r_item.quat_z); mul_b = 32'(r_item.quat_z); end
            endcase
        end else begin
            case (r_cnt)
                5'd0:    begin mul_a = ACC_W'(r_item.vel_x); mul_b = 32'(r_c); end
                5'd1:    begin mul_a = ACC_W'(r_item.vel_y); mul_b = 32'(r_s); end
                5'd2:    begin mul_a = ACC_W'(r_item.vel_x); mul_b = 32'(r_s); end
                5'd3:    begin mul_a = ACC_W'(r_item.vel_y); mul_b = 32'(r_c); end
                5'd4:    begin mul_a = r_acc_a; mul_b = r_dt; end
                default: begin mul_a = r_acc_b; mul_b = r_dt; end
            endcase
        end
    end

    logic signed [65:0] mul_full;
    assign mul_full = mul_a * mul_b;

    // vectoring start values
    logic signed [XY_W-1:0] num, den;
    assign num = XY_W'(r_acc_a) <<< 1;
    assign den = XY_W'(64'sd268435456) - (XY_W'(r_acc_b) <<< 1);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_vout       <= 1'b0;
            r_cnt        <= '0;
            r_heading    <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_last_stamp <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // result moves into the output register once it is free
            if (r_vout && (!r_out_valid || i_out_ready)) begin
                r_out.pose_x     <= r_pos_x;
                r_out.pose_y     <= r_pos_y;
                r_out.orient_z   <= r_s;
                r_out.orient_w   <= r_c;
                r_out.echo_vel_x <= r_item.vel_x;
                r_out.echo_vel_y <= r_item.vel_y;
                r_out.out_stamp  <= r_item.stamp;
                r_out_valid      <= 1'b1;
                r_vout           <= 1'b0;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_item <= i_in_data;
                        r_cnt  <= '0;
                        if (i_in_data.op == OP_HEADING) begin
                            r_state <= ST_HMUL;
                        end else begin
                            r_last_stamp <= i_in_data.stamp;
                            if (dt_new > 32'sd0) begin
                                r_dt    <= dt_new;
                                r_x     <= CORDIC_K;
                                r_y     <= '0;
                                r_z     <= ang_fold[31:0];
                                r_flip  <= ang_flip;
                                r_state <= ST_VROT1;
                            end
                        end
                    end
                end
                ST_HMUL: begin
                    r_prod <= mul_full[63:0];
                    r_cnt  <= r_cnt + 1'b1;
                    case (r_cnt)
                        5'd1:    r_acc_a <= r_prod[ACC_W-1:0];
                        5'd2:    r_acc_a <= r_acc_a + r_prod[ACC_W-1:0];
                        5'd3:    r_acc_b <= r_prod[ACC_W-1:0];
                        5'd4: begin
                            r_acc_b <= r_acc_b + r_prod[ACC_W-1:0];
                            r_state <= ST_HINIT;
                        end
                        default: ;
                    endcase
                end
                ST_HINIT: begin
                    r_cnt <= '0;
                    if (num == '0 && den == '0) begin
                        r_heading <= '0;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_state <= ST_HCORD;
                        if (den < 0) begin
                            if (num >= 0) begin
                                r_x <= num;
                                r_y <= -den;
                                r_z <= ANG_90;
                            end else begin
                                r_x <= -num;
                                r_y <= den;
                                r_z <= -ANG_90;
                            end
                        end else begin
                            r_x <= den;
                            r_y <= num;
                            r_z <= '0;
                        end
                    end
                end
                ST_HCORD: begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_z   <= n_z;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_iter) begin
                        r_heading <= 16'((n_z + 32'd32768) >> 16);
                        r_state   <= ST_IDLE;
                    end
                end
                ST_VROT1: begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_z   <= n_z;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_iter)
                        r_state <= ST_VCS;
                end
                ST_VCS: begin
                    r_c     <= r_flip ? -round_q14(r_x) : round_q14(r_x);
                    r_s     <= r_flip ? -round_q14(r_y) : round_q14(r_y);
                    r_cnt   <= '0;
                    r_state <= ST_VMUL;
                end
                ST_VMUL: begin
                    r_prod <= mul_full[63:0];
                    r_cnt  <= (r_cnt == 5'd6) ? '0 : r_cnt + 1'b1;
                    case (r_cnt)
                        5'd1:    r_acc_a <= r_prod[ACC_W-1:0];
                        5'd2:    r_acc_a <= r_acc_a - r_prod[ACC_W-1:0];
                        5'd3:    r_acc_b <= r_prod[ACC_W-1:0];
                        5'd4:    r_acc_b <= r_acc_b + r_prod[ACC_W-1:0];
                        5'd5:    r_pos_x <= sat_add(r_pos_x, r_prod);
                        5'd6: begin
                            r_pos_y <= sat_add(r_pos_y, r_prod);
                            r_x     <= CORDIC_K;
                            r_y     <= '0;
                            r_z     <= {r_heading[15], r_heading, 15'b0};
                            r_state <= ST_VROT2;
                        end
                        default: ;
                    endcase
                end
                ST_VROT2: begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_z   <= n_z;
                    r_cnt <= r_cnt + 1'b1;
                    // half-heading cos/sin held until the output register frees
                    if (last_iter) begin
                        r_c     <= round_q14(n_x);
                        r_s     <= round_q14(n_y);
                        r_vout  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE) && !r_vout)
        else $error("input ready outside idle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HCORD || r_state == ST_VROT1 || r_state == ST_VROT2)
        |-> (r_cnt < ITER_W'(CORDIC_STEPS)))
        else $error("CORDIC step counter out of range");

    a_stale_dt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.op == OP_VELOCITY && dt_new <= 32'sd0)
        |=> (r_state == ST_IDLE) && (r_last_stamp == $past(i_in_data.stamp)))
        else $error("non-positive dt item did not just store its stamp");

endmodule

// File: dv/tb_planar_odometry_integrator_top.sv
// ----------------------------------------------------------------------------
// tb_planar_odometry_integrator_top
// Drives heading and velocity transfers with random gaps on both sides,
// predicts pose, half-heading quaternion and echoes in fixed point, and
// compares every output transfer field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_planar_odometry_integrator_top
    import poi_pkg::*;
();

    localparam longint TURN_QTR  = 64'sd1073741824;
    localparam longint GAIN_K    = 64'sd652032875;
    localparam int     MAX_CYCLE = 600000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    planar_odometry_integrator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // predicted state
    logic [15:0] yaw_angle;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] prev_stamp;

    t_in_item  pending_items[$];
    t_out_item expected_poses[$];
    int        error_count;
    int        cycle_count;
    bit        stimulus_done;

    longint atan_vals[24] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335086, 667544, 333772,
        166886, 83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint round_q14(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    // rotation CORDIC, angle within +-90 deg in 2^32 per turn
    task automatic rotate_unit(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = GAIN_K; y = 0; z = ang;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_vals[i];
            end else begin
                x += dx; y -= dy; z += atan_vals[i];
            end
        end
        c = x; s = y;
    endtask

    function automatic logic [15:0] vector_angle(longint yv, longint xv);
        longint x, y, z, t, dx, dy;
        logic [31:0] zb;
        x = xv; y = yv; z = 0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = TURN_QTR;
            end else begin
                t = x; x = -y; y = t; z = -TURN_QTR;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= atan_vals[i];
            end else begin
                x += dx; y -= dy; z += atan_vals[i];
            end
        end
        zb = z[31:0] + 32'd32768;
        return zb[31:16];
    endfunction

    function automatic logic [31:0] sat_sum(logic [31:0] p, longint d);
        longint r;
        r = longint'($signed(p)) + d;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // advance the odometry state by one accepted item
    task automatic integrate_item(input t_in_item it);
        longint qx, qy, qz, qw, num, den, dt, hs, ang, c, s, hc, hsn, vx, vy, dx, dy;
        logic [31:0] diff;
        bit flip;
        t_out_item r;
        if (it.op == OP_HEADING) begin
            qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
            num = 2 * (qw * qz + qx * qy);
            den = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
            yaw_angle = vector_angle(num, den);
        end else begin
            diff = it.stamp - prev_stamp;
            dt = longint'($signed(diff));
            prev_stamp = it.stamp;
            if (dt > 0) begin
                hs = longint'($signed(yaw_angle));
                vx = it.vel_x; vy = it.vel_y;
                ang = hs * 65536; flip = 0;
                if (ang > TURN_QTR) begin
                    ang -= 2 * TURN_QTR; flip = 1;
                end else if (ang < -TURN_QTR) begin
                    ang += 2 * TURN_QTR; flip = 1;
                end
                rotate_unit(ang, c, s);
                c = round_q14(c); s = round_q14(s);
                if (flip) begin
                    c = -c; s = -s;
                end
                dx = ((vx * c - vy * s) * dt + (64'sd1 <<< 25)) >>> 26;
                dy = ((vx * s + vy * c) * dt + (64'sd1 <<< 25)) >>> 26;
                pos_x = sat_sum(pos_x, dx);
                pos_y = sat_sum(pos_y, dy);
                rotate_unit(hs * 32768, hc, hsn);
                r.pose_x     = pos_x;
                r.pose_y     = pos_y;
                r.orient_z   = 16'(round_q14(hsn));
                r.orient_w   = 16'(round_q14(hc));
                r.echo_vel_x = it.vel_x;
                r.echo_vel_y = it.vel_y;
                r.out_stamp  = it.stamp;
                expected_poses.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // input driver
    int in_wait;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait    <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) integrate_item(i_in_data);
            if (in_wait > 0 || pending_items.size() == 0) begin
                i_in_valid <= 1'b0;
                if (in_wait > 0) in_wait <= in_wait - 1;
            end else begin
                i_in_data  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                in_wait    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
        end
    end

    // output monitor and ready stalls
    int out_wait;
    always @(posedge i_clk) begin
        t_out_item w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_poses.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    w = expected_poses.pop_front();
                    if (o_out_data.pose_x !== w.pose_x)
                        report_mismatch("pose_x", o_out_data.pose_x, w.pose_x);
                    if (o_out_data.pose_y !== w.pose_y)
                        report_mismatch("pose_y", o_out_data.pose_y, w.pose_y);
                    if (o_out_data.orient_z !== w.orient_z)
                        report_mismatch("orient_z", o_out_data.orient_z, w.orient_z);
                    if (o_out_data.orient_w !== w.orient_w)
                        report_mismatch("orient_w", o_out_data.orient_w, w.orient_w);
                    if (o_out_data.echo_vel_x !== w.echo_vel_x)
                        report_mismatch("echo_vel_x", o_out_data.echo_vel_x, w.echo_vel_x);
                    if (o_out_data.echo_vel_y !== w.echo_vel_y)
                        report_mismatch("echo_vel_y", o_out_data.echo_vel_y, w.echo_vel_y);
                    if (o_out_data.out_stamp !== w.out_stamp)
                        report_mismatch("out_stamp", o_out_data.out_stamp, w.out_stamp);
                end
            end
            if (out_wait > 0) begin
                i_out_ready <= 1'b0;
                out_wait    <= out_wait - 1;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready)
                    out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("tb_planar_odometry_integrator_top failed");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic op, logic [15:0] qx, logic [15:0] qy,
                                           logic [15:0] qz, logic [15:0] qw,
                                           logic [31:0] st, logic [15:0] vx,
                                           logic [15:0] vy);
        t_in_item it;
        it.op = op; it.quat_x = qx; it.quat_y = qy; it.quat_z = qz; it.quat_w = qw;
        it.stamp = st; it.vel_x = vx; it.vel_y = vy;
        return it;
    endfunction

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom());
            1:       return 16'sd16384;
            2:       return -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    initial begin
        logic [31:0] st;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0; i_in_data = '0;
        yaw_angle = '0; pos_x = '0; pos_y = '0; prev_stamp = '0;
        error_count = 0; cycle_count = 0; stimulus_done = 0;

        // directed: zero quaternion, extremes, non-positive dt, saturation
        st = 32'h0001_0000;
        pending_items.push_back(make_item(OP_VELOCITY, 0, 0, 0, 0, st, 16'h7FFF, 16'h8000));
        pending_items.push_back(make_item(OP_HEADING, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_HEADING, 0, 0, 16'sd16384, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_VELOCITY, 0, 0, 0, 0, st + 32'h100, 16'sd4096, 0));
        pending_items.push_back(make_item(OP_VELOCITY, 0, 0, 0, 0, st, 16'sd4096, 0));
        pending_items.push_back(make_item(OP_VELOCITY, 0, 0, 0, 0, st, 16'sd4096, 0));
        pending_items.push_back(make_item(OP_HEADING, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                          32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(make_item(OP_VELOCITY, 0, 0, 0, 0, st + 32'h7FFF_FFFF,
                                          16'h7FFF, 16'h7FFF));
        pending_items.push_back(make_item(OP_HEADING, 0, 0, 16'sd11585, 16'sd11585, 0, 0, 0));
        pending_items.push_back(make_item(OP_VELOCITY, 0, 0, 0, 0, st + 32'hFFFF_FFF0,
                                          16'h8000, 16'h8000));
        pending_items.push_back(make_item(OP_HEADING, 0, 0, 0, -16'sd16384, 0, 0, 0));
        pending_items.push_back(make_item(OP_HEADING, 0, 0, -16'sd16384, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_VELOCITY, 0, 0, 0, 0, st + 32'h7FFF_FFF0,
                                          16'h8000, 16'h7FFF));
        pending_items.push_back(make_item(OP_VELOCITY, 0, 0, 0, 0, 32'h8000_0000, 16'h1, 16'h1));

        // random: mostly increasing stamps, some backwards or repeated
        st = 32'h9000_0000;
        for (int n = 0; n < 1700; n++) begin
            t_in_item it;
            it = make_item(1'b0, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                           $urandom(), $urandom(), $urandom());
            if ($urandom_range(0, 2) != 0) begin
                it.op = OP_VELOCITY;
                case ($urandom_range(0, 9))
                    0:       st = $urandom();
                    1:       st = st;
                    2:       st = st - $urandom_range(1, 65536);
                    3:       st = st + $urandom_range(0, 32'h7FFF_FFFF);
                    default: st = st + $urandom_range(1, 32'h0004_0000);
                endcase
                it.stamp = st;
            end else begin
                it.op = OP_HEADING;
            end
            pending_items.push_back(it);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !i_in_valid);
        wait (expected_poses.size() == 0);
        repeat (60) @(posedge i_clk);
        if (error_count == 0 && expected_poses.size() == 0)
            $display("tb_planar_odometry_integrator_top passed");
        else
            $display("tb_planar_odometry_integrator_top failed");
        $finish;
    end

endmodule
